### rtl/miq_pkg.sv
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types, constants and tables for the inverse quantiser.
// ----------------------------------------------------------------------------
package miq_pkg;

  localparam int unsigned CoeffW = 12;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned PosW   = 6;
  // multiplier operands: signed A, unsigned B (weights and scales < 128)
  localparam int unsigned OpaW   = 21;
  localparam int unsigned OpbW   = 7;
  localparam int unsigned ProdW  = OpaW + OpbW + 1;
  localparam int unsigned DivSh  = 5;  // divide by 32

  localparam logic signed [CoeffW-1:0] SatMax = 12'sd2047;
  localparam logic signed [CoeffW-1:0] SatMin = -12'sd2048;
  localparam logic [OpbW-1:0] NonIntraW = 7'd16;
  localparam logic [PosW-1:0] LastPos   = 6'd63;

  // configuration register indexes
  localparam logic CfgNonlinear = 1'b0;
  localparam logic CfgDcPrec    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL2 = 3'b010,
    ST_DONE = 3'b100
  } miq_state_e;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_in;
    logic                     is_intra;
    logic [CodeW-1:0]         scale_code;
  } miq_in_t;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_out;
    logic                     block_end;
  } miq_out_t;

  typedef struct packed {
    logic            load;
    logic [OpbW-1:0] op_b;
  } miq_mul_ctl_t;

  // default intra weighting matrix, raster order
  function automatic logic [OpbW-1:0] intra_weight(input logic [PosW-1:0] pos);
    logic [OpbW-1:0] w;
    case (pos)
      6'd0:  w = 7'd8;   6'd1:  w = 7'd16;  6'd2:  w = 7'd19;  6'd3:  w = 7'd22;
      6'd4:  w = 7'd26;  6'd5:  w = 7'd27;  6'd6:  w = 7'd29;  6'd7:  w = 7'd34;
      6'd8:  w = 7'd16;  6'd9:  w = 7'd16;  6'd10: w = 7'd22;  6'd11: w = 7'd24;
      6'd12: w = 7'd27;  6'd13: w = 7'd29;  6'd14: w = 7'd34;  6'd15: w = 7'd37;
      6'd16: w = 7'd19;  6'd17: w = 7'd22;  6'd18: w = 7'd26;  6'd19: w = 7'd27;
      6'd20: w = 7'd29;  6'd21: w = 7'd34;  6'd22: w = 7'd34;  6'd23: w = 7'd38;
      6'd24: w = 7'd22;  6'd25: w = 7'd22;  6'd26: w = 7'd26;  6'd27: w = 7'd27;
      6'd28: w = 7'd29;  6'd29: w = 7'd34;  6'd30: w = 7'd37;  6'd31: w = 7'd40;
      6'd32: w = 7'd22;  6'd33: w = 7'd26;  6'd34: w = 7'd27;  6'd35: w = 7'd29;
      6'd36: w = 7'd32;  6'd37: w = 7'd35;  6'd38: w = 7'd40;  6'd39: w = 7'd48;
      6'd40: w = 7'd26;  6'd41: w = 7'd27;  6'd42: w = 7'd29;  6'd43: w = 7'd32;
      6'd44: w = 7'd35;  6'd45: w = 7'd40;  6'd46: w = 7'd48;  6'd47: w = 7'd58;
      6'd48: w = 7'd26;  6'd49: w = 7'd27;  6'd50: w = 7'd29;  6'd51: w = 7'd34;
      6'd52: w = 7'd38;  6'd53: w = 7'd46;  6'd54: w = 7'd56;  6'd55: w = 7'd69;
      6'd56: w = 7'd27;  6'd57: w = 7'd29;  6'd58: w = 7'd35;  6'd59: w = 7'd38;
      6'd60: w = 7'd46;  6'd61: w = 7'd56;  6'd62: w = 7'd69;  6'd63: w = 7'd83;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic [OpbW-1:0] nonlinear_qs(input logic [CodeW-1:0] code);
    logic [OpbW-1:0] s;
    case (code)
      5'd0:  s = 7'd0;   5'd1:  s = 7'd1;   5'd2:  s = 7'd2;   5'd3:  s = 7'd3;
      5'd4:  s = 7'd4;   5'd5:  s = 7'd5;   5'd6:  s = 7'd6;   5'd7:  s = 7'd7;
      5'd8:  s = 7'd8;   5'd9:  s = 7'd10;  5'd10: s = 7'd12;  5'd11: s = 7'd14;
      5'd12: s = 7'd16;  5'd13: s = 7'd18;  5'd14: s = 7'd20;  5'd15: s = 7'd22;
      5'd16: s = 7'd24;  5'd17: s = 7'd28;  5'd18: s = 7'd32;  5'd19: s = 7'd36;
      5'd20: s = 7'd40;  5'd21: s = 7'd44;  5'd22: s = 7'd48;  5'd23: s = 7'd52;
      5'd24: s = 7'd56;  5'd25: s = 7'd64;  5'd26: s = 7'd72;  5'd27: s = 7'd80;
      5'd28: s = 7'd88;  5'd29: s = 7'd96;  5'd30: s = 7'd104; 5'd31: s = 7'd112;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/miq_mult.sv
// ----------------------------------------------------------------------------
// miq_mult
// Shared signed-by-unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module miq_mult (
  input  logic                                 clk_i,
  input  logic signed [miq_pkg::OpaW-1:0]      op_a_i,
  input  miq_pkg::miq_mul_ctl_t                ctl_i,
  output logic signed [miq_pkg::ProdW-1:0]     prod_o
);
  import miq_pkg::*;

  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;

  assign prod_d = op_a_i * $signed({1'b0, ctl_i.op_b});

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/mpeg2_inverse_quantiser_top.sv
// ----------------------------------------------------------------------------
// mpeg2_inverse_quantiser_top
// Inverse quantiser with mismatch control: two passes through one multiplier.
// ----------------------------------------------------------------------------
// Sequencing: an accepted request runs its second pass in ST_MUL2, then waits in
//   ST_DONE until the output register is free. No new request is taken while one is in
//   flight; the next request is taken in the cycle the current one commits its result.
// Reset: clears sequencer, position, parity, output valid and both registers.
module mpeg2_inverse_quantiser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  miq_pkg::miq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output miq_pkg::miq_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [1:0]        cfg_data_i
);
  import miq_pkg::*;

  miq_state_e state_q, state_d;
  logic            nonlin_q;
  logic [1:0]      dcprec_q;
  logic [PosW-1:0] pos_q;
  logic            parity_q, parity_d;
  logic            last_q;
  logic [OpbW-1:0] scale_q, scale_d;
  logic            out_valid_q;
  miq_out_t        out_q, out_d;

  logic in_acc, out_free, commit;

  // operand selection
  logic                     is_dc;
  logic signed [OpaW-1:0]   q_ext, sgn_ext, x_in, op_a;
  logic [OpbW-1:0]          w_in, s_in, dc_mul;
  miq_mul_ctl_t             mul_ctl;
  logic signed [ProdW-1:0]  prod;

  // finish
  logic signed [ProdW-1:0]  p_adj, p_div;
  logic signed [CoeffW-1:0] val;

  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == ST_DONE) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign in_acc   = in_valid_i && !in_stall_o;

  assign is_dc   = in_data_i.is_intra && (pos_q == '0);
  assign q_ext   = {{(OpaW-CoeffW){in_data_i.coeff_in[CoeffW-1]}}, in_data_i.coeff_in};
  assign sgn_ext = in_data_i.coeff_in[CoeffW-1] ? '1 :
                   ((in_data_i.coeff_in != '0) ? OpaW'(1) : '0);
  assign dc_mul  = OpbW'(4'd8 >> dcprec_q);
  assign s_in    = nonlin_q ? nonlinear_qs(in_data_i.scale_code)
                            : {1'b0, in_data_i.scale_code, 1'b0};

  always_comb begin
    if (is_dc) begin
      x_in    = q_ext;
      w_in    = dc_mul;
      // second pass by 32 cancels the common divide
      scale_d = OpbW'(1) << DivSh;
    end else if (in_data_i.is_intra) begin
      x_in    = q_ext <<< 1;
      w_in    = intra_weight(pos_q);
      scale_d = s_in;
    end else begin
      x_in    = (q_ext <<< 1) + sgn_ext;
      w_in    = NonIntraW;
      scale_d = s_in;
    end
  end

  // first pass on accept, second pass in MUL2
  always_comb begin
    if (state_q == ST_MUL2) begin
      op_a         = prod[OpaW-1:0];
      mul_ctl.op_b = scale_q;
      mul_ctl.load = 1'b1;
    end else begin
      op_a         = x_in;
      mul_ctl.op_b = w_in;
      mul_ctl.load = in_acc;
    end
  end

  miq_mult u_mult (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .ctl_i  (mul_ctl),
    .prod_o (prod)
  );

  // divide by 32 toward zero, saturate, mismatch control
  assign p_adj = prod + (prod[ProdW-1] ? ProdW'(31) : '0);
  assign p_div = p_adj >>> DivSh;

  always_comb begin
    if (p_div > ProdW'(SatMax)) begin
      val = SatMax;
    end else if (p_div < ProdW'(SatMin)) begin
      val = SatMin;
    end else begin
      val = p_div[CoeffW-1:0];
    end
    parity_d = parity_q ^ val[0];
    out_d.coeff_out = val;
    out_d.block_end = last_q;
    if (last_q) begin
      if (!parity_d) begin
        out_d.coeff_out[0] = ~val[0];
      end
      parity_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_MUL2;
      end
      ST_MUL2: state_d = ST_DONE;
      ST_DONE: begin
        if (commit) state_d = in_acc ? ST_MUL2 : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nonlin_q    <= 1'b0;
      dcprec_q    <= 2'd0;
      pos_q       <= '0;
      parity_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNonlinear: nonlin_q <= cfg_data_i[0];
          CfgDcPrec:    dcprec_q <= cfg_data_i;
          default:      ;
        endcase
      end
      if (in_acc) begin
        pos_q  <= pos_q + 1'b1;
        last_q <= (pos_q == LastPos);
      end
      if (commit) begin
        parity_q    <= parity_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scale_q <= scale_d;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (state_q == ST_IDLE || state_q == ST_DONE))
    else $error("request taken while multiplier busy");

  a_accept_mul2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MUL2)
    else $error("accepted request did not start second pass");

  a_mul2_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL2 |=> state_q == ST_DONE)
    else $error("second pass did not finish");

  a_block_end_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.block_end) |-> (parity_q == 1'b0))
    else $error("parity not cleared at block end");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives 8x8 coefficient blocks through the inverse quantiser under every
// combination of scale type and DC precision. Bursty requests and a stalling
// result sink are used throughout. Each result is compared against its typed
// directed value or an in-bench dequantiser of scaling, saturation and mismatch control.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import miq_pkg::*;

  localparam int PhaseCount  = 10;
  localparam int PhaseItems  = 150;
  localparam int SettleCycles = 6;
  localparam int HoldAt      = 700;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;
  localparam int PrintCap    = 40;

  typedef struct packed {
    miq_in_t  req;
    logic     typed;
    miq_out_t want;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  miq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  miq_out_t out_data_o;
  logic     cfg_we_i;
  logic     cfg_idx_i;
  logic [1:0] cfg_data_i;

  mpeg2_inverse_quantiser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  int weight_tab [64] = '{
     8, 16, 19, 22, 26, 27, 29, 34,
    16, 16, 22, 24, 27, 29, 34, 37,
    19, 22, 26, 27, 29, 34, 34, 38,
    22, 22, 26, 27, 29, 34, 37, 40,
    22, 26, 27, 29, 32, 35, 40, 48,
    26, 27, 29, 32, 35, 40, 48, 58,
    26, 27, 29, 34, 38, 46, 56, 69,
    27, 29, 35, 38, 46, 56, 69, 83
  };

  int qscale_tab [32] = '{
     0,  1,  2,  3,  4,  5,  6,  7,
     8, 10, 12, 14, 16, 18, 20, 22,
    24, 28, 32, 36, 40, 44, 48, 52,
    56, 64, 72, 80, 88, 96, 104, 112
  };

  // directed requests after reset: linear scale, DC multiplier 8
  dir_row_t dir_tab [20] = '{
    '{'{12'h7ff, 1'b1, 5'd1},  1'b1, '{12'h7ff, 1'b0}},  // intra DC overflow saturates
    '{'{12'h000, 1'b0, 5'd31}, 1'b1, '{12'h000, 1'b0}},  // zero stays zero
    '{'{12'h7ff, 1'b1, 5'd0},  1'b1, '{12'h000, 1'b0}},  // scale code zero
    '{'{12'h800, 1'b0, 5'd0},  1'b1, '{12'h000, 1'b0}},  // scale code zero, non-intra
    '{'{12'h800, 1'b0, 5'd31}, 1'b1, '{12'h800, 1'b0}},  // negative saturation
    '{'{12'h7ff, 1'b1, 5'd31}, 1'b1, '{12'h7ff, 1'b0}},  // positive saturation
    '{'{12'h001, 1'b0, 5'd1},  1'b0, '{12'h000, 1'b0}},
    '{'{12'hfff, 1'b0, 5'd1},  1'b0, '{12'h000, 1'b0}},
    '{'{12'h001, 1'b1, 5'd1},  1'b0, '{12'h000, 1'b0}},
    '{'{12'hfff, 1'b1, 5'd1},  1'b0, '{12'h000, 1'b0}},
    '{'{12'hfff, 1'b0, 5'd31}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'h555, 1'b1, 5'h15}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'haaa, 1'b0, 5'h0a}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'h003, 1'b1, 5'd17}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'h7ff, 1'b0, 5'd16}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'h800, 1'b1, 5'd31}, 1'b1, '{12'h800, 1'b0}},  // negative saturation, intra
    '{'{12'h007, 1'b0, 5'd3},  1'b0, '{12'h000, 1'b0}},
    '{'{12'hffb, 1'b1, 5'd9},  1'b0, '{12'h000, 1'b0}},
    '{'{12'h001, 1'b0, 5'h10}, 1'b0, '{12'h000, 1'b0}},
    '{'{12'h000, 1'b1, 5'd31}, 1'b1, '{12'h000, 1'b0}}
  };

  // dequantiser state and register copies
  logic [5:0] blk_pos;
  logic       blk_parity;
  logic       scale_nonlinear;
  logic [1:0] dc_prec;

  miq_out_t awaited_recon [$];
  int errors;
  int reqs_taken;
  int recons_seen;
  int blocks_seen;
  int settings_run;
  int burst_left;
  int cycle_cnt;
  bit hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("FAIL mpeg2_inverse_quantiser_top");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PrintCap)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic miq_out_t dequantise(input miq_in_t req);
    longint q;
    longint s;
    longint sgn;
    longint prod;
    logic signed [11:0] val;
    miq_out_t res;
    q = $signed(req.coeff_in);
    s = scale_nonlinear ? longint'(qscale_tab[req.scale_code])
                        : longint'(req.scale_code) * 2;
    sgn = (q > 0) ? 1 : ((q < 0) ? -1 : 0);
    if (req.is_intra && blk_pos == 6'd0)
      prod = q * (8 >> dc_prec);
    else if (req.is_intra)
      prod = (2 * q * longint'(weight_tab[blk_pos]) * s) / 32;
    else
      prod = ((2 * q + sgn) * 16 * s) / 32;
    if (prod > 2047) val = 12'sd2047;
    else if (prod < -2048) val = -12'sd2048;
    else val = prod[11:0];
    blk_parity = blk_parity ^ val[0];
    res.block_end = (blk_pos == 6'd63);
    if (res.block_end) begin
      // mismatch control: force the block sum odd
      if (!blk_parity) val[0] = ~val[0];
      blk_parity = 1'b0;
    end
    blk_pos = blk_pos + 6'd1;
    res.coeff_out = val;
    return res;
  endfunction

  task automatic send_req(input miq_in_t req, input logic typed, input miq_out_t want);
    int gap;
    miq_out_t recon;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(40, 1);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    recon = dequantise(req);
    awaited_recon.push_back(typed ? want : recon);
    reqs_taken++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_recon.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic nl, input logic [1:0] dcp);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgNonlinear;
    cfg_data_i <= {1'b0, nl};
    @(posedge clk_i);
    cfg_idx_i  <= CfgDcPrec;
    cfg_data_i <= dcp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scale_nonlinear = nl;
    dc_prec = dcp;
    settings_run++;
  endtask

  function automatic logic signed [11:0] pick_coeff();
    int r;
    int t;
    r = $urandom_range(99);
    if (r < 25) t = 0;
    else if (r < 65) t = int'($urandom_range(64)) - 32;
    else if (r < 85) t = $urandom;
    else if (r < 93) t = 2047 - int'($urandom_range(3));
    else t = -2048 + int'($urandom_range(3));
    return t[11:0];
  endfunction

  // result sink: stretches of different stall densities, one long hold-off
  initial begin : result_sink
    int mode;
    int span;
    int k;
    forever begin
      if (!hold_done && reqs_taken >= HoldAt) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        for (k = 0; k < HoldCycles; k++) @(posedge clk_i);
      end
      mode = $urandom_range(3);
      span = $urandom_range(120, 8);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(99) < 30);
          2: out_stall_i <= ($urandom_range(99) < 75);
          default: out_stall_i <= k[0];
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    miq_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      recons_seen++;
      if (out_data_o.block_end) blocks_seen++;
      if (awaited_recon.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data_o), 0);
      end else begin
        want = awaited_recon.pop_front();
        if (out_data_o.coeff_out !== want.coeff_out)
          report_mismatch("coeff_out", int'(out_data_o.coeff_out), int'(want.coeff_out));
        if (out_data_o.block_end !== want.block_end)
          report_mismatch("block_end", int'(out_data_o.block_end), int'(want.block_end));
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    int i;
    int run_len;
    logic nl;
    logic [1:0] dcp;
    logic run_intra;
    logic [4:0] run_code;
    miq_in_t req;

    errors = 0;
    reqs_taken = 0;
    recons_seen = 0;
    blocks_seen = 0;
    settings_run = 0;
    burst_left = 0;
    hold_done = 1'b0;
    blk_pos = '0;
    blk_parity = 1'b0;
    scale_nonlinear = 1'b0;
    dc_prec = '0;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CfgNonlinear;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < 20; i++)
      send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    for (ph = 0; ph < PhaseCount; ph++) begin
      wait_drained();
      if (ph < 8) begin
        nl  = ph[0];
        dcp = ph[2:1];
      end else begin
        nl  = 1'($urandom_range(1));
        dcp = 2'($urandom_range(3));
      end
      program_regs(nl, dcp);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(99) < 85) begin
          // rest of the current block: same type and scale to the end of the block
          run_intra = 1'($urandom_range(1));
          run_code  = 5'($urandom_range(31));
          run_len   = 64 - int'(blk_pos);
          for (i = 0; i < run_len; i++) begin
            req.coeff_in   = pick_coeff();
            req.is_intra   = run_intra;
            req.scale_code = run_code;
            send_req(req, 1'b0, '0);
          end
        end else begin
          run_len = $urandom_range(8, 1);
          for (i = 0; i < run_len; i++) begin
            req.coeff_in   = pick_coeff();
            req.is_intra   = 1'($urandom_range(1));
            req.scale_code = 5'($urandom_range(31));
            send_req(req, 1'b0, '0);
          end
        end
        n += run_len;
      end
    end

    wait_drained();
    $display("run covered %0d requests, %0d results, %0d complete blocks", reqs_taken,
             recons_seen, blocks_seen);
    $display("%0d register settings, output hold-off of %0d cycles, %0d mismatches",
             settings_run, HoldCycles, errors);
    if (errors == 0) begin
      $display("PASS mpeg2_inverse_quantiser_top");
    end else begin
      $display("FAIL mpeg2_inverse_quantiser_top");
    end
    $finish;
  end

endmodule
